>>> rtl/blru_pkg.sv
// ----------------------------------------------------------------------------
// blru_pkg: shared types and constants of the lru buffer cache
// command codes, entry record layout and result record
// ----------------------------------------------------------------------------
`default_nettype none
package blru_pkg;

  localparam int NumBuffersDefault = 64;

  localparam logic [3:0] CMD_GET         = 4'd0;
  localparam logic [3:0] CMD_RELEASE     = 4'd1;
  localparam logic [3:0] CMD_SET_DIRTY   = 4'd2;
  localparam logic [3:0] CMD_CLR_DIRTY   = 4'd3;
  localparam logic [3:0] CMD_LOCK        = 4'd4;
  localparam logic [3:0] CMD_UNLOCK      = 4'd5;
  localparam logic [3:0] CMD_SET_UPTD    = 4'd6;
  localparam logic [3:0] CMD_CLR_UPTD    = 4'd7;
  localparam logic [3:0] CMD_INVALIDATE  = 4'd8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_UNDERRUN = 2'd2;

  // one table entry as stored in the entry memory
  typedef struct packed {
    logic [15:0] dev;
    logic [31:0] blk;
    logic [7:0]  cnt;
    logic        locked;
    logic        dirty;
    logic        uptodate;
  } entry_t;

  typedef struct packed {
    logic [5:0] entry_index;
    logic       hit;
    logic [1:0] status;
    logic       is_uptodate;
    logic       is_dirty;
    logic       is_locked;
    logic [7:0] ref_count;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/blru_engine.sv
// ----------------------------------------------------------------------------
// blru_engine: command sequencer over the entry and recency memories
// walks the recency order one position at a time, reads, modifies, writes back
// ----------------------------------------------------------------------------
`default_nettype none
module blru_engine #(
  parameter int NUM_BUFFERS = blru_pkg::NumBuffersDefault
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [3:0]         cmd,
  input  wire logic [15:0]        dev,
  input  wire logic [31:0]        blk,
  input  wire logic [5:0]         idx,
  output logic                    busy,
  output logic                    done,
  output blru_pkg::result_t       res
);
  localparam int AW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam logic [AW:0] NB = (AW+1)'(NUM_BUFFERS);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_INIT   = 10'b0000000010,
    S_SRCH   = 10'b0000000100,
    S_SCAN   = 10'b0000001000,
    S_SHIFT  = 10'b0000010000,
    S_SHRD   = 10'b0000100000,
    S_IDXRD  = 10'b0001000000,
    S_IDXWR  = 10'b0010000000,
    S_INV    = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  blru_pkg::entry_t ent_mem [NUM_BUFFERS];
  logic [AW-1:0]    ord_mem [NUM_BUFFERS];

  state_t           state_r, state_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;       // issue counter
  logic [AW:0]      pos_r, pos_nxt;       // position of data arriving
  logic             ph_r, ph_nxt;         // two-read phase within a step
  logic [AW-1:0]    ord_q;                // registered order read
  blru_pkg::entry_t ent_q;                // registered entry read
  logic [AW-1:0]    e_r, e_nxt;
  logic             mv_r, mv_nxt;
  blru_pkg::result_t res_r, res_nxt;

  // memory port controls
  logic             ord_re, ent_re, ord_we, ent_we;
  logic [AW-1:0]    ord_ra, ent_ra, ord_wa, ent_wa;
  logic [AW-1:0]    ord_wd;
  blru_pkg::entry_t ent_wd;

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (ord_re) ord_q <= ord_mem[ord_ra];
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (ent_re) ent_q <= ent_mem[ent_ra];
  end

  function automatic blru_pkg::result_t rep(input logic [AW-1:0] e,
      input blru_pkg::entry_t x, input logic h, input logic [1:0] st);
    blru_pkg::result_t r;
    r.entry_index = 6'(e);
    r.hit = h;
    r.status = st;
    r.is_uptodate = x.uptodate;
    r.is_dirty = x.dirty;
    r.is_locked = x.locked;
    r.ref_count = x.cnt;
    return r;
  endfunction

  always_comb begin
    blru_pkg::entry_t x;
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    ph_nxt = ph_r;
    e_nxt = e_r;
    mv_nxt = mv_r;
    res_nxt = res_r;
    ord_re = 1'b0; ent_re = 1'b0; ord_we = 1'b0; ent_we = 1'b0;
    ord_ra = '0; ent_ra = '0; ord_wa = '0; ent_wa = '0;
    ord_wd = '0; ent_wd = '0;
    x = ent_q;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt = '0;
          ph_nxt = 1'b0;
          cnt_nxt = '0;
          if (cmd == blru_pkg::CMD_GET) begin
            state_nxt = S_SRCH;
          end else if (cmd == blru_pkg::CMD_INVALIDATE) begin
            state_nxt = S_INV;
          end else if (cmd > blru_pkg::CMD_INVALIDATE) begin
            state_nxt = S_DONE;
          end else if (32'(idx) >= NUM_BUFFERS) begin
            res_nxt.entry_index = idx;
            state_nxt = S_DONE;
          end else begin
            ent_re = 1'b1;
            ent_ra = AW'(idx);
            e_nxt = AW'(idx);
            state_nxt = S_IDXRD;
          end
        end
      end
      S_INIT: begin
        // clearing pass: order = identity, entries zero
        ord_we = 1'b1; ent_we = 1'b1;
        ord_wa = cnt_r[AW-1:0]; ent_wa = cnt_r[AW-1:0];
        ord_wd = cnt_r[AW-1:0]; ent_wd = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == NB - 1'b1) state_nxt = S_IDLE;
      end
      S_IDXRD: state_nxt = S_IDXWR;
      S_IDXWR: begin
        res_nxt.status = blru_pkg::ST_OK;
        case (cmd)
          blru_pkg::CMD_RELEASE: begin
            if (x.cnt == 8'd0) res_nxt.status = blru_pkg::ST_UNDERRUN;
            else x.cnt = x.cnt - 8'd1;
          end
          blru_pkg::CMD_SET_DIRTY: x.dirty = 1'b1;
          blru_pkg::CMD_CLR_DIRTY: x.dirty = 1'b0;
          blru_pkg::CMD_LOCK:      x.locked = 1'b1;
          blru_pkg::CMD_UNLOCK:    x.locked = 1'b0;
          blru_pkg::CMD_SET_UPTD:  x.uptodate = 1'b1;
          default:                 x.uptodate = 1'b0;
        endcase
        ent_we = 1'b1; ent_wa = e_r; ent_wd = x;
        res_nxt = rep(e_r, x, 1'b0, res_nxt.status);
        state_nxt = S_DONE;
      end
      S_INV: begin
        // phase 0 reads entry, phase 1 clears its flags if the device matches and count is zero
        if (!ph_r) begin
          ent_re = 1'b1; ent_ra = cnt_r[AW-1:0];
          ph_nxt = 1'b1;
        end else begin
          if (ent_q.dev == dev && ent_q.cnt == 8'd0) begin
            x.uptodate = 1'b0; x.dirty = 1'b0; x.locked = 1'b0;
            ent_we = 1'b1; ent_wa = cnt_r[AW-1:0]; ent_wd = x;
          end
          ph_nxt = 1'b0;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == NB - 1'b1) state_nxt = S_DONE;
        end
      end
      S_SRCH, S_SCAN: begin
        // phase 0: read order at position; phase 1: read entry; then test
        if (!ph_r) begin
          ord_re = 1'b1;
          ord_ra = (state_r == S_SRCH) ? AW'(NB - 1'b1 - cnt_r) : cnt_r[AW-1:0];
          pos_nxt = (state_r == S_SRCH) ? (NB - 1'b1 - cnt_r) : cnt_r;
          ph_nxt = 1'b1;
          mv_nxt = 1'b0;
        end else if (!mv_r) begin
          ent_re = 1'b1; ent_ra = ord_q; e_nxt = ord_q;
          mv_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          mv_nxt = 1'b0;
          if (state_r == S_SRCH && ent_q.dev == dev && ent_q.blk == blk) begin
            if (x.cnt != 8'hff) x.cnt = x.cnt + 8'd1;
            ent_we = 1'b1; ent_wa = e_r; ent_wd = x;
            res_nxt = rep(e_r, x, 1'b1, blru_pkg::ST_OK);
            if (!x.dirty && x.uptodate) begin
              mv_nxt = 1'b1; cnt_nxt = pos_r; state_nxt = S_SHRD;
            end else state_nxt = S_DONE;
          end else if (state_r == S_SCAN && ent_q.cnt == 8'd0 && !ent_q.dirty
                       && !ent_q.locked) begin
            x.dev = dev; x.blk = blk; x.cnt = 8'd1; x.uptodate = 1'b0;
            ent_we = 1'b1; ent_wa = e_r; ent_wd = x;
            res_nxt = rep(e_r, x, 1'b0, blru_pkg::ST_OK);
            mv_nxt = 1'b1; cnt_nxt = pos_r; state_nxt = S_SHRD;
          end else if (cnt_r == NB - 1'b1) begin
            cnt_nxt = '0;
            if (state_r == S_SRCH) state_nxt = S_SCAN;
            else begin
              res_nxt = '0;
              res_nxt.status = blru_pkg::ST_NO_FREE;
              state_nxt = S_DONE;
            end
          end else cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SHRD: begin
        // read order[cnt+1] for the shift, or finish at the mru end
        if (cnt_r == NB - 1'b1) begin
          ord_we = 1'b1; ord_wa = AW'(NB - 1'b1); ord_wd = e_r;
          state_nxt = S_DONE;
        end else begin
          ord_re = 1'b1; ord_ra = AW'(cnt_r + 1'b1);
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        ord_we = 1'b1; ord_wa = cnt_r[AW-1:0]; ord_wd = ord_q;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = S_SHRD;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r <= '0;
      ph_r <= 1'b0;
      mv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ph_r <= ph_nxt;
      mv_r <= mv_nxt;
    end
    pos_r <= pos_nxt;
    e_r <= e_nxt;
    res_r <= res_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);
  assign res  = res_r;
endmodule
`default_nettype wire

>>> rtl/blru_outbuf.sv
// ----------------------------------------------------------------------------
// blru_outbuf: output register holding one result item
// ----------------------------------------------------------------------------
`default_nettype none
module blru_outbuf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire blru_pkg::result_t din,
  output logic                   full,
  input  wire logic              take,
  output blru_pkg::result_t      dout
);
  logic              full_r;
  blru_pkg::result_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) full_r <= 1'b0;
    else if (load) full_r <= 1'b1;
    else if (take) full_r <= 1'b0;
    if (load) data_r <= din;
  end

  assign full = full_r;
  assign dout = data_r;
endmodule
`default_nettype wire

>>> rtl/block_buffer_lru_cache.sv
// ----------------------------------------------------------------------------
// block_buffer_lru_cache: lru managed table of block buffer descriptors
// get, release, flag and invalidate commands over one stream channel
// ----------------------------------------------------------------------------
// usage
//  - in_* carries one command item; out_* returns exactly one result item
//  - a get walks the recency memory from the mru end (tag search) and, on a
//    miss, from the lru end (free victim scan), reading order, then entry,
//    then testing at each position; it then shifts the order one position at
//    a time to move the entry to mru, but a hit that is dirty or not up to
//    date stays in place
//  - the walk through the recency memory sets how long a get takes
//  - one item is worked on at a time; the next is taken once the result
//    is in the output register, which parts the two sides
//  - after reset a clearing pass over every entry loads the identity
//    order and zero entries; in_tready stays low meanwhile
//  - a stalled out_tready holds the result; the next item can still start
//    but its result waits until the register drains
// ----------------------------------------------------------------------------
`default_nettype none
module block_buffer_lru_cache #(
  parameter int NUM_BUFFERS = blru_pkg::NumBuffersDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // command[3:0], device[19:4], block_number[51:20], buffer_index[57:52]
  input  wire logic [63:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // entry_index[5:0], hit[6], status[8:7], is_uptodate[9], is_dirty[10],
  // is_locked[11], ref_count[19:12]
  output logic [23:0]      out_tdata
);
  logic              busy, done, full, start;
  blru_pkg::result_t eres, ores;
  logic [3:0]        cmd_r;
  logic [15:0]       dev_r;
  logic [31:0]       blk_r;
  logic [5:0]        idx_r;
  logic              pend_r;   // result done but output register still full

  // engine may start only when idle and no finished result waits
  assign in_tready = !busy && !pend_r;
  assign start = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r <= in_tdata[3:0];
      dev_r <= in_tdata[19:4];
      blk_r <= in_tdata[51:20];
      idx_r <= in_tdata[57:52];
    end
  end

  blru_engine #(.NUM_BUFFERS(NUM_BUFFERS)) u_eng (
    .clk(clk), .rst_n(rst_n), .start(start),
    .cmd(start ? in_tdata[3:0] : cmd_r),
    .dev(start ? in_tdata[19:4] : dev_r),
    .blk(start ? in_tdata[51:20] : blk_r),
    .idx(start ? in_tdata[57:52] : idx_r),
    .busy(busy), .done(done), .res(eres)
  );

  // hold a finished result until the output register is free
  blru_pkg::result_t hold_r;
  logic load;
  logic take;
  assign take = out_tvalid && out_tready;
  assign load = (done || pend_r) && (!full || take);

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 1'b0;
    else if (load) pend_r <= 1'b0;
    else if (done) pend_r <= 1'b1;
    if (done) hold_r <= eres;
  end

  blru_outbuf u_out (
    .clk(clk), .rst_n(rst_n), .load(load),
    .din(done ? eres : hold_r), .full(full), .take(take), .dout(ores)
  );

  assign out_tvalid = full;
  assign out_tdata = {4'd0, ores.ref_count, ores.is_locked, ores.is_dirty,
                      ores.is_uptodate, ores.status, ores.hit, ores.entry_index};
endmodule
`default_nettype wire

>>> rtl/blru_checker.sv
// ----------------------------------------------------------------------------
// blru_checker: port level checks of the lru buffer cache
// ----------------------------------------------------------------------------
`default_nettype none
module blru_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_nostatus3: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:7] != 2'd3)
    else $error("bad status code");
  a_nofree_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8:7] == 2'd1 |-> out_tdata[6:0] == 7'd0)
    else $error("no free result not zero");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");
endmodule

bind block_buffer_lru_cache blru_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the lru buffer cache
// drives directed and random command streams with idle gaps on both sides, predicts each
// result from a model of the entry table and recency order, compares fields
// ----------------------------------------------------------------------------
`default_nettype none
module tb;

  localparam int NB = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  block_buffer_lru_cache #(.NUM_BUFFERS(NB)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // shadow copy of the cache state
  logic [5:0]  recency[NB];
  logic [15:0] shadow_dev[NB];
  logic [31:0] shadow_blk[NB];
  logic [7:0]  shadow_cnt[NB];
  logic        shadow_uptd[NB];
  logic        shadow_dirty[NB];
  logic        shadow_lock[NB];

  logic [63:0]       pending_cmds[$];
  blru_pkg::result_t expected_results[$];
  int          fail_count;
  int          idle_cycles;
  bit          stim_done;
  bit          hold_off;
  int          in_gap;
  int          out_gap;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] pack_cmd(logic [3:0] c, logic [15:0] d,
                                           logic [31:0] b, logic [5:0] i);
    return {6'd0, i, b, d, c};
  endfunction

  function automatic blru_pkg::result_t entry_result(int e, logic h, logic [1:0] st);
    blru_pkg::result_t r;
    r.entry_index = e[5:0];
    r.hit         = h;
    r.status      = st;
    r.is_uptodate = shadow_uptd[e];
    r.is_dirty    = shadow_dirty[e];
    r.is_locked   = shadow_lock[e];
    r.ref_count   = shadow_cnt[e];
    return r;
  endfunction

  function automatic void promote_to_mru(int pos);
    logic [5:0] e;
    e = recency[pos];
    for (int p = pos; p < NB - 1; p++) recency[p] = recency[p + 1];
    recency[NB - 1] = e;
  endfunction

  // apply one command to the shadow state and return the expected result
  function automatic blru_pkg::result_t cache_predict(logic [63:0] item);
    logic [3:0]  c;
    logic [15:0] d;
    logic [31:0] b;
    logic [5:0]  i;
    int          e;
    blru_pkg::result_t r;
    c = item[3:0];
    d = item[19:4];
    b = item[51:20];
    i = item[57:52];
    r = '0;
    if (c == blru_pkg::CMD_GET) begin
      // tag search from the mru end
      for (int p = NB - 1; p >= 0; p--) begin
        e = recency[p];
        if (shadow_dev[e] == d && shadow_blk[e] == b) begin
          if (shadow_cnt[e] != 8'hff) shadow_cnt[e]++;
          if (!shadow_dirty[e] && shadow_uptd[e]) promote_to_mru(p);
          return entry_result(e, 1'b1, blru_pkg::ST_OK);
        end
      end
      // victim scan from the lru end
      for (int p = 0; p < NB; p++) begin
        e = recency[p];
        if (shadow_cnt[e] == 0 && !shadow_dirty[e] && !shadow_lock[e]) begin
          promote_to_mru(p);
          shadow_dev[e]  = d;
          shadow_blk[e]  = b;
          shadow_cnt[e]  = 8'd1;
          shadow_uptd[e] = 1'b0;
          return entry_result(e, 1'b0, blru_pkg::ST_OK);
        end
      end
      r.status = blru_pkg::ST_NO_FREE;
      return r;
    end
    if (c == blru_pkg::CMD_INVALIDATE) begin
      for (int k = 0; k < NB; k++)
        if (shadow_dev[k] == d && shadow_cnt[k] == 0) begin
          shadow_uptd[k]  = 1'b0;
          shadow_dirty[k] = 1'b0;
          shadow_lock[k]  = 1'b0;
        end
      return r;
    end
    if (c > blru_pkg::CMD_INVALIDATE) return r;
    if (int'(i) >= NB) begin
      r.entry_index = i;
      return r;
    end
    e = i;
    r = '0;
    case (c)
      blru_pkg::CMD_RELEASE: begin
        if (shadow_cnt[e] == 0) r.status = blru_pkg::ST_UNDERRUN;
        else shadow_cnt[e]--;
      end
      blru_pkg::CMD_SET_DIRTY: shadow_dirty[e] = 1'b1;
      blru_pkg::CMD_CLR_DIRTY: shadow_dirty[e] = 1'b0;
      blru_pkg::CMD_LOCK:      shadow_lock[e]  = 1'b1;
      blru_pkg::CMD_UNLOCK:    shadow_lock[e]  = 1'b0;
      blru_pkg::CMD_SET_UPTD:  shadow_uptd[e]  = 1'b1;
      default:                 shadow_uptd[e]  = 1'b0;
    endcase
    return entry_result(e, 1'b0, r.status);
  endfunction

  function automatic int pick_gap();
    // mostly back to back, sometimes short, rarely long
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7, 8:    return $urandom_range(1, 3);
      default:       return $urandom_range(10, 60);
    endcase
  endfunction

  // small tag pool so gets hit, miss and exhaust the table
  function automatic logic [63:0] random_cmd();
    logic [3:0]  c;
    logic [15:0] d;
    logic [31:0] b;
    int          sel;
    sel = $urandom_range(0, 99);
    if (sel < 40)      c = blru_pkg::CMD_GET;
    else if (sel < 60) c = blru_pkg::CMD_RELEASE;
    else if (sel < 95) c = 4'($urandom_range(2, 7));
    else if (sel < 98) c = blru_pkg::CMD_INVALIDATE;
    else               c = 4'($urandom_range(9, 15));
    d = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    b = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 47));
    // indexes always inside the table so flags and releases hit live entries
    return pack_cmd(c, d, b, 6'($urandom_range(0, 63)));
  endfunction

  // ---------------------------------------------------------------- stimulus
  initial begin
    for (int k = 0; k < NB; k++) begin
      recency[k] = 6'(k);
      shadow_dev[k] = '0;
      shadow_blk[k] = '0;
      shadow_cnt[k] = '0;
      shadow_uptd[k] = 1'b0;
      shadow_dirty[k] = 1'b0;
      shadow_lock[k] = 1'b0;
    end
    // reset tag hits the mru entry
    pending_cmds.push_back(pack_cmd(blru_pkg::CMD_GET, 16'd0, 32'd0, 6'd0));
    pending_cmds.push_back(pack_cmd(blru_pkg::CMD_GET, 16'hffff, 32'hffffffff, 6'd0));
    pending_cmds.push_back(pack_cmd(blru_pkg::CMD_RELEASE, 16'd0, 32'd0, 6'd63));
    // release of an unreferenced entry
    pending_cmds.push_back(pack_cmd(blru_pkg::CMD_RELEASE, 16'd0, 32'd0, 6'd5));
    for (int c = blru_pkg::CMD_SET_DIRTY; c <= blru_pkg::CMD_CLR_UPTD; c++)
      pending_cmds.push_back(pack_cmd(4'(c), 16'd0, 32'd0, 6'd10));
    // lock of a locked entry
    pending_cmds.push_back(pack_cmd(blru_pkg::CMD_LOCK, 16'd0, 32'd0, 6'd10));
    pending_cmds.push_back(pack_cmd(blru_pkg::CMD_LOCK, 16'd0, 32'd0, 6'd10));
    pending_cmds.push_back(pack_cmd(blru_pkg::CMD_INVALIDATE, 16'd0, 32'd0, 6'd0));
    pending_cmds.push_back(pack_cmd(4'd9, 16'h5555, 32'haaaaaaaa, 6'd21));
    pending_cmds.push_back(pack_cmd(4'd15, 16'haaaa, 32'h55555555, 6'd42));
    // exhaust the table: fill every free entry, then the last gets find none free
    for (int k = 0; k < NB; k++)
      pending_cmds.push_back(pack_cmd(blru_pkg::CMD_GET, 16'd7, 32'(k + 100), 6'd0));
    pending_cmds.push_back(pack_cmd(blru_pkg::CMD_GET, 16'd7, 32'd999, 6'd0));
    // saturate one count
    for (int k = 0; k < 256; k++)
      pending_cmds.push_back(pack_cmd(blru_pkg::CMD_GET, 16'd7, 32'd100, 6'd0));
    // release every entry more than once; most of these releases underrun
    for (int k = 0; k < NB + 260; k++)
      pending_cmds.push_back(pack_cmd(blru_pkg::CMD_RELEASE, 16'd0, 32'd0, 6'(k % NB)));
    for (int k = 0; k < 240; k++) pending_cmds.push_back(random_cmd());
  end

  // ------------------------------------------------------------------ driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      // the current item (if any) was taken at this edge
      if (in_tvalid) expected_results.push_back(cache_predict(in_tdata));
      if (in_gap > 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        in_tdata  <= pending_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_gap    <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk) begin
    blru_pkg::result_t got;
    blru_pkg::result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.entry_index = out_tdata[5:0];
        got.hit         = out_tdata[6];
        got.status      = out_tdata[8:7];
        got.is_uptodate = out_tdata[9];
        got.is_dirty    = out_tdata[10];
        got.is_locked   = out_tdata[11];
        got.ref_count   = out_tdata[19:12];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.entry_index !== want.entry_index || got.hit !== want.hit ||
              got.status !== want.status || got.is_uptodate !== want.is_uptodate ||
              got.is_dirty !== want.is_dirty || got.is_locked !== want.is_locked ||
              got.ref_count !== want.ref_count || out_tdata[23:20] !== 4'd0) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            fail_count++;
          end
        end
      end
      if (hold_off) out_tready <= 1'b0;
      else if (out_gap > 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready) out_gap <= pick_gap();
      end
    end
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    hold_off = 1'b0;
    wait (rst_n);
    repeat (3000) @(posedge clk);
    hold_off = 1'b1;
    repeat (2000) @(posedge clk);
    hold_off = 1'b0;
  end

  // ---------------------------------------------------------- watchdog, end
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_off)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    fail_count = 0;
    idle_cycles = 0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && expected_results.size() == 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles < WATCHDOG_LIMIT) begin
      repeat (1200) @(posedge clk);
      if (!out_tvalid && fail_count == 0) $display("** block_buffer_lru_cache: PASSED **");
      else $display("** block_buffer_lru_cache: FAILED **");
    end else begin
      $display("%0t: timeout", $time);
      $display("** block_buffer_lru_cache: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
